// ===== sv/dlr_pkg.sv =====
// Shared types and constants for the DDA line rasterizer.
// Used by dlr_ctrl, dlr_datapath and dda_line_rasterizer; no dependencies.
`default_nettype none

package dlr_pkg;

    // default geometry of the fixed-point position
    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 16;

    // configuration register widths
    localparam int BASE_W   = 32;
    localparam int DIM_W    = 13;
    localparam int PITCH_W  = 15;
    localparam int FMT_W    = 2;
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FB_BASE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PIX_FMT       = 3'd4;

    // reset values
    localparam logic [BASE_W-1:0]  RST_FB_BASE       = 32'd0;
    localparam logic [DIM_W-1:0]   RST_SCREEN_WIDTH  = 13'd1024;
    localparam logic [DIM_W-1:0]   RST_SCREEN_HEIGHT = 13'd768;
    localparam logic [PITCH_W-1:0] RST_ROW_PITCH     = 15'd4096;
    localparam logic [FMT_W-1:0]   RST_PIX_FMT       = 2'd2;

    // input commands
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // byte counts
    localparam logic [2:0] BYTES_3 = 3'd3;
    localparam logic [2:0] BYTES_4 = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_PIX,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [BASE_W-1:0]  fb_base;
        logic [DIM_W-1:0]   screen_width;
        logic [DIM_W-1:0]   screen_height;
        logic [PITCH_W-1:0] row_pitch;
        logic [FMT_W-1:0]   pix_fmt;
    } cfg_t;

    // controller -> datapath
    typedef struct packed {
        logic load_start;  // start beat accepted
        logic load_step;   // step beat accepted
        logic div_run;     // one divide iteration
        logic pix_run;     // pixel address stage
        logic out_load;    // load output register
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic steps_zero;  // incoming start describes a single pixel
        logic div_done;    // last divide iteration this cycle
        logic out_free;    // output register can take a beat
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== sv/dlr_ctrl.sv =====
// Sequencing controller for the DDA line rasterizer.
// Depends on dlr_pkg; drives the datapath through dp_cmd_t.
`default_nettype none

module dlr_ctrl
    import dlr_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    input  wire logic     s_command,
    output logic          s_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        accept     = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_DIV: begin
                cmd.div_run = 1'b1;
                if (stat.div_done) begin
                    state_next = ST_PIX;
                end
            end
            ST_PIX: begin
                cmd.pix_run = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT: begin
                // the finished beat leaves and the next one may come in together
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    s_ready      = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        accept = s_valid && s_ready;
        if (accept) begin
            if (s_command == CMD_START) begin
                cmd.load_start = 1'b1;
                state_next     = stat.steps_zero ? ST_PIX : ST_DIV;
            end else begin
                cmd.load_step = 1'b1;
                state_next    = ST_PIX;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/dlr_datapath.sv =====
// Datapath of the DDA line rasterizer: endpoint setup, serial increment
// divider, position accumulators, address formatting and output register.
// Depends on dlr_pkg; controlled by dlr_ctrl.
`default_nettype none

module dlr_datapath
    import dlr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire cfg_t                  cfg,
    input  wire logic [COORD_BITS-1:0] s_start_x,
    input  wire logic [COORD_BITS-1:0] s_start_y,
    input  wire logic [COORD_BITS-1:0] s_end_x,
    input  wire logic [COORD_BITS-1:0] s_end_y,
    input  wire logic [31:0]           s_line_color,
    input  wire dp_cmd_t               cmd,
    output dp_stat_t                   stat,
    input  wire logic                  m_ready,
    output logic                       m_valid,
    output logic [31:0]                m_write_address,
    output logic [31:0]                m_write_data,
    output logic [2:0]                 m_byte_count,
    output logic                       m_write_enable,
    output logic                       m_last_pixel,
    output logic                       m_no_line
);

    localparam int C      = COORD_BITS;
    localparam int F      = FRAC_BITS;
    localparam int POS_W  = C + 1 + F;
    localparam int STEP_W = F + 2;
    localparam int Q_W    = F + 1;
    localparam int REM_W  = C + 1;
    localparam int CNT_W  = $clog2(F + 1);
    localparam int PROD_W = C + PITCH_W;
    localparam int XOFF_W = C + 2;
    localparam int CMP_W  = (C > DIM_W) ? C : DIM_W;

    // line state
    logic [POS_W-1:0]  x_pos_reg, x_pos_next;
    logic [POS_W-1:0]  y_pos_reg, y_pos_next;
    logic [STEP_W-1:0] x_step_reg, x_step_next;
    logic [STEP_W-1:0] y_step_reg, y_step_next;
    logic [C-1:0]      pixels_left_reg, pixels_left_next;
    logic [31:0]       color_reg, color_next;
    logic              active_reg, active_next;
    logic              last_reg, last_next;
    logic              nl_reg, nl_next;

    // divider
    logic [C-1:0]      steps_reg, steps_next;
    logic [REM_W-1:0]  rem_x_reg, rem_x_next;
    logic [REM_W-1:0]  rem_y_reg, rem_y_next;
    logic [Q_W-1:0]    q_x_reg, q_x_next;
    logic [Q_W-1:0]    q_y_reg, q_y_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              x_neg_reg, x_neg_next;
    logic              y_neg_reg, y_neg_next;

    // pixel stage
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [XOFF_W-1:0] xoff_reg, xoff_next;
    logic              en_reg, en_next;
    logic              plast_reg, plast_next;
    logic              pnl_reg, pnl_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic [31:0]       addr_reg, addr_next;
    logic [31:0]       data_reg, data_next;
    logic [2:0]        bcnt_reg, bcnt_next;
    logic              wen_reg, wen_next;
    logic              olast_reg, olast_next;
    logic              onl_reg, onl_next;

    // combinational helpers
    logic [REM_W-1:0]  dx, dy, dx_neg, dy_neg;
    logic [C-1:0]      abs_x, abs_y, steps_in;
    logic              ge_x, ge_y;
    logic [REM_W-1:0]  r_x, r_y;
    logic [Q_W-1:0]    q_x_it, q_y_it;
    logic [STEP_W-1:0] qx_ext, qy_ext;
    logic [C-1:0]      pl_dec;
    logic [C-1:0]      px, py;
    logic              on_screen;
    logic              bpp4;

    // setup from the incoming endpoints
    always_comb begin
        dx       = {1'b0, s_end_x} - {1'b0, s_start_x};
        dy       = {1'b0, s_end_y} - {1'b0, s_start_y};
        dx_neg   = -dx;
        dy_neg   = -dy;
        abs_x    = dx[C] ? dx_neg[C-1:0] : dx[C-1:0];
        abs_y    = dy[C] ? dy_neg[C-1:0] : dy[C-1:0];
        steps_in = (abs_x >= abs_y) ? abs_x : abs_y;
    end

    // one restoring step per lane: remainder stays below twice the divisor
    always_comb begin
        ge_x   = rem_x_reg >= {1'b0, steps_reg};
        ge_y   = rem_y_reg >= {1'b0, steps_reg};
        r_x    = ge_x ? (rem_x_reg - {1'b0, steps_reg}) : rem_x_reg;
        r_y    = ge_y ? (rem_y_reg - {1'b0, steps_reg}) : rem_y_reg;
        q_x_it = {q_x_reg[Q_W-2:0], ge_x};
        q_y_it = {q_y_reg[Q_W-2:0], ge_y};
        qx_ext = {1'b0, q_x_it};
        qy_ext = {1'b0, q_y_it};
    end

    assign bpp4   = cfg.pix_fmt[1];
    assign pl_dec = pixels_left_reg - 1'b1;
    assign px     = x_pos_reg[POS_W-2:F];
    assign py     = y_pos_reg[POS_W-2:F];
    assign on_screen = !x_pos_reg[POS_W-1] && !y_pos_reg[POS_W-1]
                    && (CMP_W'(px) < CMP_W'(cfg.screen_width))
                    && (CMP_W'(py) < CMP_W'(cfg.screen_height));

    assign stat.steps_zero = (steps_in == '0);
    assign stat.div_done   = (cnt_reg == '0);
    assign stat.out_free   = !m_valid_reg || m_ready;

    always_comb begin
        x_pos_next       = x_pos_reg;
        y_pos_next       = y_pos_reg;
        x_step_next      = x_step_reg;
        y_step_next      = y_step_reg;
        pixels_left_next = pixels_left_reg;
        color_next       = color_reg;
        active_next      = active_reg;
        last_next        = last_reg;
        nl_next          = nl_reg;
        steps_next       = steps_reg;
        rem_x_next       = rem_x_reg;
        rem_y_next       = rem_y_reg;
        q_x_next         = q_x_reg;
        q_y_next         = q_y_reg;
        cnt_next         = cnt_reg;
        x_neg_next       = x_neg_reg;
        y_neg_next       = y_neg_reg;

        if (cmd.load_start) begin
            x_pos_next       = {1'b0, s_start_x, {F{1'b0}}};
            y_pos_next       = {1'b0, s_start_y, {F{1'b0}}};
            x_step_next      = '0;
            y_step_next      = '0;
            color_next       = s_line_color;
            pixels_left_next = steps_in;
            active_next      = (steps_in != '0);
            last_next        = (steps_in == '0);
            nl_next          = 1'b0;
            steps_next       = steps_in;
            rem_x_next       = {1'b0, abs_x};
            rem_y_next       = {1'b0, abs_y};
            q_x_next         = '0;
            q_y_next         = '0;
            cnt_next         = CNT_W'(F);
            x_neg_next       = dx[C];
            y_neg_next       = dy[C];
        end else if (cmd.load_step) begin
            if (active_reg) begin
                x_pos_next = x_pos_reg
                           + {{(POS_W-STEP_W){x_step_reg[STEP_W-1]}}, x_step_reg};
                y_pos_next = y_pos_reg
                           + {{(POS_W-STEP_W){y_step_reg[STEP_W-1]}}, y_step_reg};
                pixels_left_next = pl_dec;
                active_next      = (pl_dec != '0);
                last_next        = (pl_dec == '0);
                nl_next          = 1'b0;
            end else begin
                last_next = 1'b0;
                nl_next   = 1'b1;
            end
        end else if (cmd.div_run) begin
            rem_x_next = {r_x[C-1:0], 1'b0};
            rem_y_next = {r_y[C-1:0], 1'b0};
            q_x_next   = q_x_it;
            q_y_next   = q_y_it;
            cnt_next   = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                // truncation toward zero: divide magnitudes, then apply sign
                x_step_next = x_neg_reg ? -qx_ext : qx_ext;
                y_step_next = y_neg_reg ? -qy_ext : qy_ext;
            end
        end
    end

    // pixel stage: clip test and the address products
    always_comb begin
        prod_next  = prod_reg;
        xoff_next  = xoff_reg;
        en_next    = en_reg;
        plast_next = plast_reg;
        pnl_next   = pnl_reg;
        if (cmd.pix_run) begin
            prod_next  = PROD_W'(py) * PROD_W'(cfg.row_pitch);
            xoff_next  = bpp4 ? {px, 2'b00} : ({1'b0, px, 1'b0} + {2'b00, px});
            en_next    = on_screen && !nl_reg;
            plast_next = last_reg;
            pnl_next   = nl_reg;
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        addr_next    = addr_reg;
        data_next    = data_reg;
        bcnt_next    = bcnt_reg;
        wen_next     = wen_reg;
        olast_next   = olast_reg;
        onl_next     = onl_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
            addr_next    = en_reg ? (cfg.fb_base + 32'(prod_reg) + 32'(xoff_reg))
                                  : 32'd0;
            data_next    = en_reg ? {(bpp4 ? color_reg[31:24] : 8'h00),
                                     color_reg[7:0], color_reg[15:8], color_reg[23:16]}
                                  : 32'd0;
            bcnt_next    = bpp4 ? BYTES_4 : BYTES_3;
            wen_next     = en_reg;
            olast_next   = plast_reg;
            onl_next     = pnl_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            x_pos_reg   <= '0;
            y_pos_reg   <= '0;
            x_step_reg  <= '0;
            y_step_reg  <= '0;
            pixels_left_reg <= '0;
            color_reg   <= '0;
        end else begin
            active_reg  <= active_next;
            m_valid_reg <= m_valid_next;
            x_pos_reg   <= x_pos_next;
            y_pos_reg   <= y_pos_next;
            x_step_reg  <= x_step_next;
            y_step_reg  <= y_step_next;
            pixels_left_reg <= pixels_left_next;
            color_reg   <= color_next;
        end
    end

    always_ff @(posedge aclk) begin
        last_reg  <= last_next;
        nl_reg    <= nl_next;
        steps_reg <= steps_next;
        rem_x_reg <= rem_x_next;
        rem_y_reg <= rem_y_next;
        q_x_reg   <= q_x_next;
        q_y_reg   <= q_y_next;
        cnt_reg   <= cnt_next;
        x_neg_reg <= x_neg_next;
        y_neg_reg <= y_neg_next;
        prod_reg  <= prod_next;
        xoff_reg  <= xoff_next;
        en_reg    <= en_next;
        plast_reg <= plast_next;
        pnl_reg   <= pnl_next;
        addr_reg  <= addr_next;
        data_reg  <= data_next;
        bcnt_reg  <= bcnt_next;
        wen_reg   <= wen_next;
        olast_reg <= olast_next;
        onl_reg   <= onl_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_write_address = addr_reg;
    assign m_write_data    = data_reg;
    assign m_byte_count    = bcnt_reg;
    assign m_write_enable  = wen_reg;
    assign m_last_pixel    = olast_reg;
    assign m_no_line       = onl_reg;

endmodule

`default_nettype wire

// ===== sv/dda_line_rasterizer.sv =====
// DDA line rasterizer: s_ channel takes start and step commands, m_ channel
// gives one framebuffer write beat per command. A start beat loads the
// endpoints and color and yields pixel 0; each step beat yields the next
// pixel until max(|dx|,|dy|)+1 pixels are out. A step with no line active
// yields a beat with no_line set and write_enable low.
// A step beat goes through the pixel stage and then the output register; a
// start beat first passes through the bit-serial divider that forms both
// increments (one quotient bit per cycle per axis). A zero-length start
// skips the divider. A new command is not taken while one is in the divider
// or pixel stage; s_ready rises in the cycle the previous beat moves into
// the output register, so a waiting result does not hold off the next
// command. If m_ready stays low the finished beat waits in the output
// register and the block holds its next result in the pixel stage.
// Configuration writes go through cfg_write_enable/cfg_index/cfg_data, take
// effect at once and must only be issued while the block is idle.
// Reset (aresetn low, synchronous): the configuration registers return to
// their defaults, no line is active and m_valid drops.
// Depends on dlr_pkg, dlr_ctrl and dlr_datapath.
`default_nettype none

module dda_line_rasterizer
    import dlr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_write_enable,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [31:0]           cfg_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_command,
    input  wire logic [COORD_BITS-1:0] s_start_x,
    input  wire logic [COORD_BITS-1:0] s_start_y,
    input  wire logic [COORD_BITS-1:0] s_end_x,
    input  wire logic [COORD_BITS-1:0] s_end_y,
    input  wire logic [31:0]           s_line_color,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [31:0]                m_write_address,
    output logic [31:0]                m_write_data,
    output logic [2:0]                 m_byte_count,
    output logic                       m_write_enable,
    output logic                       m_last_pixel,
    output logic                       m_no_line
);

    cfg_t     cfg_reg, cfg_next;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_write_enable) begin
            case (cfg_index)
                REG_FB_BASE:       cfg_next.fb_base       = cfg_data[BASE_W-1:0];
                REG_SCREEN_WIDTH:  cfg_next.screen_width  = cfg_data[DIM_W-1:0];
                REG_SCREEN_HEIGHT: cfg_next.screen_height = cfg_data[DIM_W-1:0];
                REG_ROW_PITCH:     cfg_next.row_pitch     = cfg_data[PITCH_W-1:0];
                REG_PIX_FMT:       cfg_next.pix_fmt       = cfg_data[FMT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fb_base       <= RST_FB_BASE;
            cfg_reg.screen_width  <= RST_SCREEN_WIDTH;
            cfg_reg.screen_height <= RST_SCREEN_HEIGHT;
            cfg_reg.row_pitch     <= RST_ROW_PITCH;
            cfg_reg.pix_fmt       <= RST_PIX_FMT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    dlr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_command (s_command),
        .s_ready   (s_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    dlr_datapath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .s_start_x       (s_start_x),
        .s_start_y       (s_start_y),
        .s_end_x         (s_end_x),
        .s_end_y         (s_end_y),
        .s_line_color    (s_line_color),
        .cmd             (cmd),
        .stat            (stat),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_write_address (m_write_address),
        .m_write_data    (m_write_data),
        .m_byte_count    (m_byte_count),
        .m_write_enable  (m_write_enable),
        .m_last_pixel    (m_last_pixel),
        .m_no_line       (m_no_line)
    );

`ifndef ASSERT_OFF
    // a new beat never overwrites one that has not been taken
    a_out_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("output register overwritten while full");

    // a step without a line writes nothing and ends nothing
    a_no_line_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_no_line) |-> (!m_write_enable && !m_last_pixel
                                    && m_write_address == 32'd0))
        else $error("no-line beat carries a write");

    // byte count follows the current pixel format
    a_byte_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_byte_count == (cfg_reg.pix_fmt[1] ? BYTES_4 : BYTES_3)))
        else $error("byte count does not match pixel format");
`endif

endmodule

`default_nettype wire
